>>> src/gsr_pkg.sv
`timescale 1ns / 1ps
package gsr_pkg;

   localparam int ROW_IDX_W  = 16;
   localparam int BYTE_IDX_W = 12;
   localparam int LEN_W      = 7;

   localparam logic [7:0]       GF_POLY_LOW     = 8'h1D;
   localparam logic [LEN_W-1:0] SYMBOL_LEN_RST  = 7'd64;
   localparam int               CSR_ADDR_W      = 3;
   localparam logic             CSR_IDX_SYM_LEN = 1'b0;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_AXPY  = 2'd2,
      REQ_SCALE = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type           kind;
      logic [ROW_IDX_W-1:0]   dst;
      logic [ROW_IDX_W-1:0]   src;
      logic [BYTE_IDX_W-1:0]  byte_sel;
      logic [7:0]             wbyte;
      logic [7:0]             mul;
      logic [LEN_W-1:0]       count;
   } job_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] acc;
      x   = a;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc = acc ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
      end
      return acc;
   endfunction

endpackage

>>> src/gsr_if.sv
`timescale 1ns / 1ps
interface gsr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] dst_row;
   logic [7:0] src_row;
   logic [5:0] byte_index;
   logic [7:0] write_byte;
   logic [7:0] multiplier;

   modport source (output valid, req_type, dst_row, src_row, byte_index, write_byte,
                   multiplier, input ready);
   modport sink (input valid, req_type, dst_row, src_row, byte_index, write_byte,
                 multiplier, output ready);
endinterface

interface gsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       done_res;

   modport source (output valid, read_byte, done_res, input ready);
   modport sink (input valid, read_byte, done_res, output ready);
endinterface

>>> src/gsr_front.sv
`timescale 1ns / 1ps
module gsr_front
   import gsr_pkg::*;
#(
   parameter int MAX_ROWS         = 256,
   parameter int MAX_SYMBOL_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   gsr_req_if.sink          req_if,
   input  logic [LEN_W-1:0] symbol_len,
   output job_type          job,
   output logic             job_valid,
   input  logic             job_ready
);

   localparam int QD = 4;
   localparam int QW = $clog2(QD);

   job_type        q_ff [QD];
   logic [QW-1:0]  wr_ptr_ff;
   logic [QW-1:0]  rd_ptr_ff;
   logic [QW:0]    fill_ff;

   logic           dst_ok;
   logic           src_ok;
   logic           byte_ok;
   logic [31:0]    len_w;
   logic [LEN_W-1:0] len_sat;
   job_type        new_job;
   logic           push;
   logic           pop;

   always_comb begin
      dst_ok  = 32'(req_if.dst_row) < 32'(MAX_ROWS);
      src_ok  = 32'(req_if.src_row) < 32'(MAX_ROWS);
      byte_ok = 32'(req_if.byte_index) < 32'(MAX_SYMBOL_BYTES);
      len_w   = (32'(symbol_len) > 32'(MAX_SYMBOL_BYTES)) ? 32'(MAX_SYMBOL_BYTES)
                                                          : 32'(symbol_len);
      len_sat = len_w[LEN_W-1:0];

      new_job.kind     = req_kind_type'(req_if.req_type);
      new_job.dst      = ROW_IDX_W'(req_if.dst_row);
      new_job.src      = ROW_IDX_W'(req_if.src_row);
      new_job.byte_sel = BYTE_IDX_W'(req_if.byte_index);
      new_job.wbyte    = req_if.write_byte;
      new_job.mul      = req_if.multiplier;
      case (new_job.kind)
         REQ_WRITE, REQ_READ: new_job.count = (dst_ok && byte_ok) ? LEN_W'(1) : '0;
         REQ_AXPY:            new_job.count = (dst_ok && src_ok) ? len_sat : '0;
         REQ_SCALE:           new_job.count = dst_ok ? len_sat : '0;
         default:             new_job.count = '0;
      endcase
   end

   assign req_if.ready = (fill_ff != (QW+1)'(QD));
   assign push         = req_if.valid && req_if.ready;
   assign job_valid    = (fill_ff != '0);
   assign job          = q_ff[rd_ptr_ff];
   assign pop          = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            q_ff[wr_ptr_ff] <= new_job;
            wr_ptr_ff       <= wr_ptr_ff + QW'(1);
         end
         if (pop) rd_ptr_ff <= rd_ptr_ff + QW'(1);
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + (QW+1)'(1);
            2'b01:   fill_ff <= fill_ff - (QW+1)'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

>>> src/gsr_back.sv
`timescale 1ns / 1ps
module gsr_back
   import gsr_pkg::*;
#(
   parameter int MAX_ROWS         = 256,
   parameter int MAX_SYMBOL_BYTES = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  job_type  job,
   input  logic     job_valid,
   output logic     job_ready,
   gsr_rsp_if.source rsp_if
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int BW    = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;
   localparam int AW    = RW + BW;
   localparam int DEPTH = MAX_ROWS * (1 << BW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   state_type          state_ff;
   job_type            cur_ff;
   logic [LEN_W-1:0]   k_ff;
   logic               p1_ff;
   logic [AW-1:0]      wa_ff;
   logic [7:0]         rda_ff;
   logic [7:0]         rdb_ff;
   logic [7:0]         rbyte_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;

   logic [7:0]         mem [DEPTH];

   logic [BYTE_IDX_W-1:0] k_wide;
   logic [BW-1:0]      col;
   logic [AW-1:0]      addr_a;
   logic [AW-1:0]      addr_b;
   logic               mem_we;
   logic [7:0]         wr_data;
   logic               out_free;

   always_comb begin
      k_wide = BYTE_IDX_W'(k_ff);
      if (cur_ff.kind == REQ_WRITE || cur_ff.kind == REQ_READ) col = cur_ff.byte_sel[BW-1:0];
      else col = k_wide[BW-1:0];
      addr_a = {cur_ff.src[RW-1:0], col};
      addr_b = {cur_ff.dst[RW-1:0], col};
      mem_we = p1_ff && (cur_ff.kind != REQ_READ);
      case (cur_ff.kind)
         REQ_WRITE: wr_data = cur_ff.wbyte;
         REQ_AXPY:  wr_data = rdb_ff ^ gf_mul(cur_ff.mul, rda_ff);
         REQ_SCALE: wr_data = gf_mul(cur_ff.mul, rdb_ff);
         default:   wr_data = rdb_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wa_ff] <= wr_data;
      rda_ff <= mem[addr_a];
      rdb_ff <= mem[addr_b];
   end

   assign job_ready        = (state_ff == ST_IDLE);
   assign out_free         = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_byte = rsp_byte_ff;
   assign rsp_if.done_res  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         p1_ff <= (state_ff == ST_RUN);
         wa_ff <= addr_b;
         if (p1_ff && cur_ff.kind == REQ_READ) rbyte_ff <= rdb_ff;
         if (state_ff == ST_RESP && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  cur_ff   <= job;
                  k_ff     <= '0;
                  rbyte_ff <= '0;
                  state_ff <= (job.count == '0) ? ST_RESP : ST_RUN;
               end
            end
            ST_RUN: begin
               k_ff <= k_ff + LEN_W'(1);
               if (k_ff + LEN_W'(1) == cur_ff.count) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_byte_ff  <= rbyte_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> src/gf256_symbol_row_op_engine.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// req_if    in         valid/ready                    req_type dst_row src_row byte_index
//                                                     write_byte multiplier
// rsp_if    out        valid/ready                    read_byte done_res
// csr_*     in         APB write setup+access         symbol_len at byte address 0
//
// A byte request takes the back end through run, drain and response; a row request stays
// in run for len bytes, len being symbol_len clipped to MAX_SYMBOL_BYTES, one byte per
// cycle through the symbol memory (two read ports, one write port). A request that
// touches nothing goes straight to response. A four-entry request queue keeps accepting while the back end works.
// Reset is synchronous; the symbol memory is not cleared and needs no clearing pass.
// A stalled response holds in the output register; the back end runs on to the next one.
module gf256_symbol_row_op_engine
   import gsr_pkg::*;
#(
   parameter int MAX_ROWS         = 256,
   parameter int MAX_SYMBOL_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   gsr_req_if.sink               req_if,
   gsr_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0] symbol_len_ff;
   job_type          job;
   logic             job_valid;
   logic             job_ready;
   logic             csr_hit;

   assign csr_hit    = (csr_paddr[2] == CSR_IDX_SYM_LEN);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? 32'(symbol_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_len_ff <= SYMBOL_LEN_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         symbol_len_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   gsr_front #(
      .MAX_ROWS         (MAX_ROWS),
      .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .symbol_len (symbol_len_ff),
      .job        (job),
      .job_valid  (job_valid),
      .job_ready  (job_ready)
   );

   gsr_back #(
      .MAX_ROWS         (MAX_ROWS),
      .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .rsp_if    (rsp_if)
   );

endmodule

>>> src/gsr_checker.sv
`timescale 1ns / 1ps
module gsr_checker
   import gsr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_read_byte,
   input logic                  rsp_done_res,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]           csr_pwdata,
   input logic [31:0]           csr_prdata
);

   logic [3:0] pend_ff;
   logic       req_acc;
   logic       rsp_acc;
   logic       len_wr;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign len_wr  = csr_psel && csr_penable && csr_pwrite &&
                    (csr_paddr[2] == CSR_IDX_SYM_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         case ({req_acc, rsp_acc})
            2'b10:   pend_ff <= pend_ff + 4'd1;
            2'b01:   pend_ff <= pend_ff - 4'd1;
            default: pend_ff <= pend_ff;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte))
      else $error("response dropped or changed while stalled");

   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res)
      else $error("response without acknowledgement");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("response with no request outstanding");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 4'd6)
      else $error("more requests in flight than queue and stages hold");

   a_len_readback: assert property (@(posedge clock) disable iff (reset)
      len_wr && !reset |=> csr_paddr[2] != CSR_IDX_SYM_LEN ||
                           csr_prdata == 32'($past(csr_pwdata[LEN_W-1:0])))
      else $error("symbol length register lost a write");

endmodule

bind gf256_symbol_row_op_engine gsr_checker u_gsr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_byte (rsp_if.read_byte),
   .rsp_done_res  (rsp_if.done_res),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);
